FILE: hw/rtl/assert_macros.svh
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lis_pkg.sv
package lis_pkg;

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int LIS_W   = 7;

    // default store capacity
    localparam int MAX_ELEMENTS_DEF = 64;

    // input word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_t;

    // result word
    typedef struct packed {
        logic [LIS_W-1:0] lis_length;
        logic             overflow;
    } out_t;

endpackage

FILE: hw/rtl/lis_store.sv
module lis_store
    import lis_pkg::*;
#(
    parameter int DEPTH  = MAX_ELEMENTS_DEF,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 39
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/lis_cmp.sv
module lis_cmp
    import lis_pkg::*;
#(
    parameter int LEN_W = 7
)
(
    input  logic signed [VALUE_W-1:0] key,
    input  logic signed [VALUE_W-1:0] elem,
    input  logic        [LEN_W-1:0]   elem_len,
    input  logic        [LEN_W-1:0]   cur_len,
    output logic        [LEN_W-1:0]   new_len
);

    logic [LEN_W:0] cand;
    logic           smaller;

    // one predecessor: extend its run if it is strictly smaller
    always_comb
    begin
        cand    = {1'b0, elem_len} + {{LEN_W{1'b0}}, 1'b1};
        smaller = (elem < key);
        if (smaller && (cand > {1'b0, cur_len}))
        begin
            new_len = cand[LEN_W-1:0];
        end
        else
        begin
            new_len = cur_len;
        end
    end

endmodule

FILE: hw/rtl/lis_length_quadratic_dp_core.sv
// channel  | handshake         | payload
// ---------+-------------------+---------------------------------
// input    | start / busy      | item   (value, last)
// result   | done (one cycle)  | result (lis_length, overflow)
//
// after an element is taken, busy stays high while it is compared with each
// stored predecessor in turn through the shared comparator, reading one store
// entry per cycle, and through a finish step that writes it back.
// a dropped element (store full) goes straight to the finish step, unwritten.
// done pulses in the cycle after the finish step of a word with last set.
// the receiver cannot stall; reset clears counters, no store sweep is needed.
`include "assert_macros.svh"

module lis_length_quadratic_dp_core
    import lis_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  item,
    output logic done,
    output out_t result
);

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int LEN_W  = CNT_W;
    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int DATA_W = VALUE_W + LEN_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                state_reg,  state_next;
    logic signed [VALUE_W-1:0] key_reg,    key_next;
    logic                      last_reg,   last_next;
    logic                      full_reg,   full_next;
    logic [CNT_W-1:0]          count_reg,  count_next;
    logic [LEN_W-1:0]          best_reg,   best_next;
    logic                      drop_reg,   drop_next;
    logic [LEN_W-1:0]          len_reg,    len_next;
    logic [ADDR_W-1:0]         idx_reg,    idx_next;
    logic                      done_reg,   done_next;
    out_t                      result_reg, result_next;

    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [LEN_W-1:0]  cmp_len;
    logic [LEN_W-1:0]  best_upd;
    logic              drop_upd;
    logic [CNT_W-1:0]  idx_plus;

    // element and ending length share one store entry
    lis_store #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({key_reg, len_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared compare and extend unit
    lis_cmp #(
        .LEN_W (LEN_W)
    ) u_cmp (
        .key      (key_reg),
        .elem     (rd_data[DATA_W-1:LEN_W]),
        .elem_len (rd_data[LEN_W-1:0]),
        .cur_len  (len_reg),
        .new_len  (cmp_len)
    );

    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);
    assign busy     = (state_reg != ST_IDLE);
    assign wr_en    = (state_reg == ST_FINISH) && !full_reg;

    // read address: entry 0 on accept, next entry while scanning
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            rd_addr = idx_plus[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // running best and overflow as seen at the end of this word
    always_comb
    begin
        best_upd = best_reg;
        drop_upd = drop_reg;
        if (full_reg)
        begin
            drop_upd = 1'b1;
        end
        else if (len_reg > best_reg)
        begin
            best_upd = len_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        last_next   = last_reg;
        full_next   = full_reg;
        count_next  = count_reg;
        best_next   = best_reg;
        drop_next   = drop_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next  = item.value;
                    last_next = item.last;
                    len_next  = LEN_W'(1);
                    idx_next  = '0;
                    full_next = (count_reg == CNT_W'(MAX_ELEMENTS));
                    if ((count_reg == CNT_W'(MAX_ELEMENTS)) || (count_reg == '0))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                len_next = cmp_len;
                if (idx_plus == count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_plus[ADDR_W-1:0];
                end
            end

            ST_FINISH:
            begin
                state_next = ST_IDLE;
                best_next  = best_upd;
                drop_next  = drop_upd;
                if (!full_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (last_reg)
                begin
                    done_next              = 1'b1;
                    result_next.lis_length = LIS_W'(best_upd);
                    result_next.overflow   = drop_upd;
                    count_next             = '0;
                    best_next              = '0;
                    drop_next              = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            best_reg  <= '0;
            drop_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            best_reg  <= best_next;
            drop_reg  <= drop_next;
            done_reg  <= done_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        last_reg   <= last_next;
        full_reg   <= full_next;
        len_reg    <= len_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `ASSERT_CLK(a_count_range, count_reg <= CNT_W'(MAX_ELEMENTS), "element count above capacity")
    `ASSERT_IMPL(a_done_idle, done_reg, (state_reg == ST_IDLE) && (count_reg == '0),
        "result strobe without a cleared sequence")
    `ASSERT_IMPL(a_scan_index, state_reg == ST_SCAN, idx_plus <= count_reg,
        "scan index past stored elements")
    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `ASSERT_IMPL(a_done_len, done_reg, result_reg.lis_length != '0 || LEN_W > LIS_W,
        "result length of zero")

endmodule

FILE: sim/lis_result_checker.sv
`timescale 1ns / 100ps

module lis_result_checker
    import lis_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  in_t  item,
    input  logic done,
    input  out_t result,
    output int   pending,
    output int   mismatches,
    output int   results_checked
);

    // running state of the sequence being received
    logic signed [VALUE_W-1:0] seen_value [MAX_ELEMENTS];
    int                        ending_len [MAX_ELEMENTS];
    int                        seen_count = 0;
    int                        best_len   = 0;
    logic                      dropped    = 1'b0;
    out_t                      expected_lis_q [$];
    int                        err_count  = 0;
    int                        ok_count   = 0;

    assign mismatches      = err_count;
    assign results_checked = ok_count;

    // fold one taken word into the sequence, queue the longest length and overflow on last
    task automatic predict_lis(input in_t w);
        int   len;
        out_t want;
        if (seen_count < MAX_ELEMENTS)
        begin
            len = 1;
            for (int j = 0; j < seen_count; j++)
            begin
                if (seen_value[j] < $signed(w.value) && ending_len[j] + 1 > len)
                    len = ending_len[j] + 1;
            end
            seen_value[seen_count] = $signed(w.value);
            ending_len[seen_count] = len;
            seen_count++;
            if (len > best_len)
                best_len = len;
        end
        else
        begin
            // store full: word is dropped but still counts for last
            dropped = 1'b1;
        end
        if (w.last)
        begin
            want.lis_length = LIS_W'(best_len);
            want.overflow   = dropped;
            expected_lis_q.push_back(want);
            seen_count = 0;
            best_len   = 0;
            dropped    = 1'b0;
        end
    endtask

    // compare one result word against the oldest prediction
    task automatic check_lis(input out_t got);
        out_t want;
        if (expected_lis_q.size() == 0)
        begin
            $error("unexpected result word: lis_length %0d overflow %0b",
                   got.lis_length, got.overflow);
            err_count++;
        end
        else
        begin
            want = expected_lis_q.pop_front();
            ok_count++;
            if (got.lis_length !== want.lis_length)
            begin
                $error("lis_length: expected %0d, actual %0d",
                       want.lis_length, got.lis_length);
                err_count++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                err_count++;
            end
        end
    endtask

    // watch both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_count = 0;
            best_len   = 0;
            dropped    = 1'b0;
            expected_lis_q.delete();
            pending <= 0;
        end
        else
        begin
            if ($isunknown({busy, done}))
            begin
                $error("busy or done unknown after reset");
                err_count++;
            end
            // a result never belongs to a word taken at the same edge
            if (done)
                check_lis(result);
            if (start && !busy)
                predict_lis(item);
            pending <= expected_lis_q.size();
        end
    end

endmodule

FILE: sim/tb_lis_length_quadratic_dp_core.sv
`timescale 1ns / 100ps

module tb_lis_length_quadratic_dp_core;
    import lis_pkg::*;

    localparam int CAPACITY     = MAX_ELEMENTS_DEF;
    localparam int RANDOM_WORDS = 450;
    localparam int STALL_LIMIT  = 1000;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // how the elements of a random sequence are drawn
    typedef enum int {FULL_RANGE, NARROW, RISING_WALK, EXTREMES, STRICT_RAMP} value_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  item  = '0;
    logic busy;
    logic done;
    out_t result;
    int   pending;
    int   mismatches;
    int   results_checked;

    int   stall_cycles   = 0;
    bit   quiet          = 1'b0;
    int   words_sent     = 0;
    int   sequences_sent = 0;
    int   overfull_sent  = 0;
    logic signed [VALUE_W-1:0] seq_q [$];

    always #5 clk = ~clk;

    lis_length_quadratic_dp_core #(.MAX_ELEMENTS(CAPACITY)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    lis_result_checker #(.MAX_ELEMENTS(CAPACITY)) u_lis_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .done            (done),
        .result          (result),
        .pending         (pending),
        .mismatches      (mismatches),
        .results_checked (results_checked)
    );

    // watchdog on cycles where neither channel moves a word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // offer one word, with an occasional idle gap, and hold it until taken
    task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic l);
        int gap;
        in_t w;
        gap = (!quiet && $urandom_range(0, 99) < 6) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.value = v;
        w.last  = l;
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // send the queued sequence, last flag on its final element
    task automatic send_queued();
        foreach (seq_q[i])
            send_word(seq_q[i], i == seq_q.size() - 1);
        sequences_sent++;
        if (seq_q.size() > CAPACITY)
            overfull_sent++;
        seq_q.delete();
    endtask

    // hold off until every predicted result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // fill the sequence queue with len elements drawn per mode
    task automatic build_seq(input int len, input value_mode_t mode);
        int walk;
        walk = int'($urandom_range(0, 200)) - 100;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                FULL_RANGE:  seq_q.push_back($urandom);
                NARROW:      seq_q.push_back(int'($urandom_range(0, 20)) - 10);
                RISING_WALK:
                begin
                    walk += int'($urandom_range(0, 24)) - 6;
                    seq_q.push_back(walk);
                end
                STRICT_RAMP:
                begin
                    walk += 1 + int'($urandom_range(0, 1000));
                    seq_q.push_back(walk);
                end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       seq_q.push_back(VALUE_MIN);
                        1:       seq_q.push_back(VALUE_MAX);
                        2:       seq_q.push_back(0);
                        3:       seq_q.push_back(-1);
                        default: seq_q.push_back($urandom);
                    endcase
                end
            endcase
        end
    endtask

    initial
    begin
        int random_base;
        int n_seq;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single element, extremes in both orders, equal values, sign crossing, a falling run, a ramp at the extremes
        seq_q = '{VALUE_MAX};
        send_queued();
        seq_q = '{VALUE_MIN, VALUE_MAX};
        send_queued();
        seq_q = '{VALUE_MAX, VALUE_MIN};
        send_queued();
        seq_q = '{0, 0};
        send_queued();
        seq_q = '{-1, 0, 1, 1, -5, 2};
        send_queued();
        seq_q = '{5, 4, 3, 2, 1};
        send_queued();
        seq_q = '{VALUE_MIN, VALUE_MIN + 1, VALUE_MAX - 1, VALUE_MAX};
        send_queued();
        wait_drained();

        // random sequences, mostly short, a few near, at or past the store size
        random_base = words_sent;
        n_seq = 0;
        while (words_sent - random_base < RANDOM_WORDS)
        begin
            quiet = (n_seq >= 20 && n_seq < 45);
            if (n_seq == 0)
                build_seq(CAPACITY + 3, STRICT_RAMP);
            else if (n_seq == 1)
                build_seq(CAPACITY, STRICT_RAMP);
            else if ($urandom_range(0, 99) < 4)
                build_seq($urandom_range(CAPACITY - 2, CAPACITY + 6),
                          value_mode_t'($urandom_range(0, 4)));
            else
                build_seq($urandom_range(1, 12), value_mode_t'($urandom_range(0, 4)));
            send_queued();
            if ($urandom_range(0, 15) == 0)
                wait_drained();
            n_seq++;
        end

        // drain, then leave room for any stray result
        wait_drained();
        repeat (2 * CAPACITY + 8) @(posedge clk);

        $display("covered %0d words in %0d sequences, %0d of them past the %0d-entry store",
                 words_sent, sequences_sent, overfull_sent, CAPACITY);
        $display("%0d lis results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lis_pkg.sv
hw/rtl/lis_store.sv
hw/rtl/lis_cmp.sv
hw/rtl/lis_length_quadratic_dp_core.sv
sim/lis_result_checker.sv
sim/tb_lis_length_quadratic_dp_core.sv
